[rtl/graphic_degree_sequence_test_defines.svh]
// assertion macros for the graphic degree sequence test
`ifndef GRAPHIC_DEGREE_SEQUENCE_TEST_DEFINES_SVH
`define GRAPHIC_DEGREE_SEQUENCE_TEST_DEFINES_SVH

`ifndef SYNTH
`define GDST_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define GDST_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GDST_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define GDST_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[rtl/gdst_pkg.sv]
`timescale 1ns / 1ps
package gdst_pkg;

    typedef struct packed {
        logic sum_odd;
        logic overflowed;
    } job_flags_t;

    typedef struct packed {
        logic graphic;
        logic overflow;
    } result_t;

endpackage

[rtl/gdst_front.sv]
`timescale 1ns / 1ps
module gdst_front #(
    parameter int MAX_VERTICES = 1024,
    parameter int DEGREE_BITS  = 16,
    parameter int CW           = $clog2(MAX_VERTICES + 1),
    parameter int AW           = $clog2(MAX_VERTICES),
    parameter int SUM_W        = DEGREE_BITS + CW
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [15:0]             s_degree,
    input  logic                    s_last,
    output logic                    wr_en,
    output logic [AW-1:0]           wr_addr,
    output logic [DEGREE_BITS-1:0]  wr_data,
    output logic                    push,
    output logic [CW-1:0]           job_count,
    output logic [SUM_W-1:0]        job_total,
    output gdst_pkg::job_flags_t    job_flags,
    input  logic                    job_done
);
    import gdst_pkg::*;

    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_VERTICES);

    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic [SUM_W-1:0]       total_reg;
    logic [SUM_W-1:0]       total_next;
    logic                   ovf_reg;
    logic                   ovf_next;
    logic                   busy_reg;
    logic [31:0]            deg_ext;
    logic [DEGREE_BITS-1:0] deg;
    logic                   accept;
    logic                   room;

    assign deg_ext = {16'b0, s_degree};
    assign deg     = deg_ext[DEGREE_BITS-1:0];
    assign s_ready = !busy_reg;
    assign accept  = s_valid && s_ready;
    assign room    = count_reg < CNT_MAX;

    always_comb begin
        count_next = count_reg;
        total_next = total_reg;
        ovf_next   = ovf_reg;
        if (room) begin
            count_next = count_reg + CW'(1);
            total_next = total_reg + SUM_W'(deg);
        end else begin
            ovf_next = 1'b1;
        end
    end

    assign wr_en     = accept && room;
    assign wr_addr   = count_reg[AW-1:0];
    assign wr_data   = deg;
    assign push      = accept && s_last;
    assign job_count = count_next;
    assign job_total = total_next;
    assign job_flags = '{sum_odd: total_next[0], overflowed: ovf_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            total_reg <= '0;
            ovf_reg   <= 1'b0;
            busy_reg  <= 1'b0;
        end else begin
            if (accept) begin
                if (s_last) begin
                    count_reg <= '0;
                    total_reg <= '0;
                    ovf_reg   <= 1'b0;
                    busy_reg  <= 1'b1;
                end else begin
                    count_reg <= count_next;
                    total_reg <= total_next;
                    ovf_reg   <= ovf_next;
                end
            end else if (job_done) begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule

[rtl/gdst_fifo.sv]
`timescale 1ns / 1ps
module gdst_fifo #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         empty,
    output logic [W-1:0] pop_data
);
    import gdst_pkg::*;

    logic [W-1:0] entry_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   fill_reg;

    assign full     = fill_reg == 2'd2;
    assign empty    = fill_reg == 2'd0;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop && !empty) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
        end
    end

endmodule

[rtl/gdst_back.sv]
`timescale 1ns / 1ps
module gdst_back #(
    parameter int MAX_VERTICES = 1024,
    parameter int DEGREE_BITS  = 16,
    parameter int CW           = $clog2(MAX_VERTICES + 1),
    parameter int AW           = $clog2(MAX_VERTICES),
    parameter int SUM_W        = DEGREE_BITS + CW
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    fe_wr_en,
    input  logic [AW-1:0]           fe_wr_addr,
    input  logic [DEGREE_BITS-1:0]  fe_wr_data,
    input  logic                    job_empty,
    output logic                    job_pop,
    input  logic [CW-1:0]           job_count,
    input  logic [SUM_W-1:0]        job_total,
    input  gdst_pkg::job_flags_t    job_flags,
    output logic                    job_done,
    output logic                    m_valid,
    input  logic                    m_ready,
    output gdst_pkg::result_t       result
);
    import gdst_pkg::*;

    localparam int PW     = CW + 2;
    localparam int PROD_W = 2 * CW;
    localparam int RW     = ((PROD_W > SUM_W) ? PROD_W : SUM_W) + 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PASS  = 4'd1;
    localparam logic [3:0] S_SEG   = 4'd2;
    localparam logic [3:0] S_M_RD  = 4'd3;
    localparam logic [3:0] S_M_WR  = 4'd4;
    localparam logic [3:0] S_C_RD  = 4'd5;
    localparam logic [3:0] S_C_EV  = 4'd6;
    localparam logic [3:0] S_C_CMP = 4'd7;
    localparam logic [3:0] S_RES   = 4'd8;

    logic [DEGREE_BITS-1:0] mem0 [MAX_VERTICES];
    logic [DEGREE_BITS-1:0] mem1 [MAX_VERTICES];
    logic [DEGREE_BITS-1:0] rd0a_reg, rd0b_reg, rd1a_reg, rd1b_reg;

    logic [3:0]        state_reg;
    logic              sel_reg;
    logic [PW-1:0]     n_reg, w_reg, lo_reg, mid_reg, hi_reg, i_reg, j_reg, o_reg;
    logic [PW-1:0]     k_reg, q_reg;
    logic [SUM_W-1:0]  total_reg, left_reg, tail_reg, tsel_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              m_valid_reg;
    result_t           result_reg;
    result_t           res_pend_reg;

    logic [AW-1:0]          ra, rb;
    logic [DEGREE_BITS-1:0] a_val, b_val;
    logic                   take_a;
    logic [DEGREE_BITS-1:0] mw_data;
    logic                   mw_en;
    logic [PW-1:0]          mid_c, hi_c, lo_next, ind, qm1, km1;
    logic [SUM_W-1:0]       left_next;
    logic [RW-1:0]          right;
    logic                   dq_small;
    logic                   out_free;

    assign a_val = sel_reg ? rd1a_reg : rd0a_reg;
    assign b_val = sel_reg ? rd1b_reg : rd0b_reg;
    assign qm1   = q_reg - PW'(1);
    assign km1   = k_reg - PW'(1);

    always_comb begin
        ra = i_reg[AW-1:0];
        rb = j_reg[AW-1:0];
        if (state_reg == S_C_RD) begin
            ra = km1[AW-1:0];
            rb = qm1[AW-1:0];
        end
    end

    assign take_a  = (i_reg < mid_reg) && ((j_reg >= hi_reg) || (a_val >= b_val));
    assign mw_data = take_a ? a_val : b_val;
    assign mw_en   = state_reg == S_M_WR;
    assign mid_c   = ((lo_reg + w_reg) < n_reg) ? lo_reg + w_reg : n_reg;
    assign hi_c    = ((mid_c + w_reg) < n_reg) ? mid_c + w_reg : n_reg;
    assign lo_next = lo_reg + (w_reg << 1);
    assign ind     = (q_reg > k_reg) ? q_reg : k_reg;
    assign left_next = left_reg + SUM_W'(a_val);
    assign dq_small  = (q_reg != '0) && (SUM_W'(b_val) < SUM_W'(k_reg[CW-1:0]));
    assign right     = RW'(prod_reg) + RW'(tsel_reg);
    assign out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (fe_wr_en) begin
            mem0[fe_wr_addr] <= fe_wr_data;
        end else if (mw_en && sel_reg) begin
            mem0[o_reg[AW-1:0]] <= mw_data;
        end
        if (mw_en && !sel_reg) begin
            mem1[o_reg[AW-1:0]] <= mw_data;
        end
        rd0a_reg <= mem0[ra];
        rd0b_reg <= mem0[rb];
        rd1a_reg <= mem1[ra];
        rd1b_reg <= mem1[rb];
    end

    assign job_pop  = (state_reg == S_IDLE) && !job_empty;
    assign job_done = (state_reg == S_RES) && out_free;
    assign m_valid  = m_valid_reg;
    assign result   = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            sel_reg     <= 1'b0;
        end else begin
            if (job_done) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (!job_empty) begin
                        n_reg     <= PW'(job_count);
                        total_reg <= job_total;
                        sel_reg   <= 1'b0;
                        w_reg     <= PW'(1);
                        if (job_flags.overflowed) begin
                            res_pend_reg <= '{graphic: 1'b0, overflow: 1'b1};
                            state_reg    <= S_RES;
                        end else if (job_flags.sum_odd) begin
                            res_pend_reg <= '{graphic: 1'b0, overflow: 1'b0};
                            state_reg    <= S_RES;
                        end else begin
                            state_reg <= S_PASS;
                        end
                    end
                end
                S_PASS: begin
                    lo_reg <= '0;
                    if (w_reg >= n_reg) begin
                        k_reg     <= PW'(1);
                        q_reg     <= n_reg;
                        tail_reg  <= '0;
                        left_reg  <= '0;
                        state_reg <= S_C_RD;
                    end else begin
                        state_reg <= S_SEG;
                    end
                end
                S_SEG: begin
                    mid_reg   <= mid_c;
                    hi_reg    <= hi_c;
                    i_reg     <= lo_reg;
                    j_reg     <= mid_c;
                    o_reg     <= lo_reg;
                    state_reg <= S_M_RD;
                end
                S_M_RD: begin
                    state_reg <= S_M_WR;
                end
                S_M_WR: begin
                    if (take_a) begin
                        i_reg <= i_reg + PW'(1);
                    end else begin
                        j_reg <= j_reg + PW'(1);
                    end
                    o_reg <= o_reg + PW'(1);
                    if (o_reg + PW'(1) == hi_reg) begin
                        if (lo_next >= n_reg) begin
                            w_reg     <= w_reg << 1;
                            sel_reg   <= !sel_reg;
                            state_reg <= S_PASS;
                        end else begin
                            lo_reg    <= lo_next;
                            state_reg <= S_SEG;
                        end
                    end else begin
                        state_reg <= S_M_RD;
                    end
                end
                S_C_RD: begin
                    state_reg <= S_C_EV;
                end
                S_C_EV: begin
                    if (dq_small) begin
                        tail_reg  <= tail_reg + SUM_W'(b_val);
                        q_reg     <= qm1;
                        state_reg <= S_C_RD;
                    end else begin
                        left_reg  <= left_next;
                        prod_reg  <= PROD_W'(k_reg[CW-1:0]) * PROD_W'(ind[CW-1:0] - CW'(1));
                        tsel_reg  <= (q_reg > k_reg) ? tail_reg : total_reg - left_next;
                        state_reg <= S_C_CMP;
                    end
                end
                S_C_CMP: begin
                    if (RW'(left_reg) > right) begin
                        res_pend_reg <= '{graphic: 1'b0, overflow: 1'b0};
                        state_reg    <= S_RES;
                    end else if (k_reg == n_reg) begin
                        res_pend_reg <= '{graphic: 1'b1, overflow: 1'b0};
                        state_reg    <= S_RES;
                    end else begin
                        k_reg     <= k_reg + PW'(1);
                        state_reg <= S_C_RD;
                    end
                end
                S_RES: begin
                    if (out_free) begin
                        result_reg <= res_pend_reg;
                        state_reg  <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/graphic_degree_sequence_test.sv]
`timescale 1ns / 1ps
// graphic degree sequence test (erdos-gallai)
// input channel s_*: one degree per word, s_last marks the final degree of a sequence
// result channel m_*: one word per sequence, m_graphic and m_overflow
// degrees load at one per cycle into the store while no sequence is in flight
// after the last word the front takes no input until the check has handed its result
// to the output register; the check then runs out of a two-entry job queue
// after the last word an overflowed or odd-sum sequence goes straight to the result;
// otherwise the merge sort runs ceil(log2 n) passes over the n degrees, each with a
// pass state, a segment state per segment and a read and a write state per element,
// then the scan takes a read, an evaluate and a compare state per k and a read and
// an evaluate state per step of the lower-degree pointer
// the two-port store memories bound the sort to a read state and a write state per element
// reset clears the state, valid and queue pointer registers; loop registers, results and store need no clearing
// a stalled receiver holds the result in the output register, the next sequence may
// load meanwhile and its check runs but hands over its result once the register is free
module graphic_degree_sequence_test #(
    parameter int MAX_VERTICES = 1024,
    parameter int DEGREE_BITS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_degree,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_graphic,
    output logic        m_overflow
);
    import gdst_pkg::*;

    `include "graphic_degree_sequence_test_defines.svh"

    localparam int CW    = $clog2(MAX_VERTICES + 1);
    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int SUM_W = DEGREE_BITS + CW;
    localparam int JW    = CW + SUM_W + $bits(job_flags_t);

    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [DEGREE_BITS-1:0] wr_data;
    logic                   push;
    logic [CW-1:0]          fe_count;
    logic [SUM_W-1:0]       fe_total;
    job_flags_t             fe_flags;
    logic                   job_done;
    logic                   q_full;
    logic                   q_empty;
    logic                   q_pop;
    logic [JW-1:0]          q_out;
    logic [CW-1:0]          be_count;
    logic [SUM_W-1:0]       be_total;
    job_flags_t             be_flags;
    result_t                result;

    gdst_front #(
        .MAX_VERTICES(MAX_VERTICES),
        .DEGREE_BITS (DEGREE_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_degree (s_degree),
        .s_last   (s_last),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .push     (push),
        .job_count(fe_count),
        .job_total(fe_total),
        .job_flags(fe_flags),
        .job_done (job_done)
    );

    gdst_fifo #(
        .W(JW)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data({fe_count, fe_total, fe_flags}),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .pop_data (q_out)
    );

    assign {be_count, be_total, be_flags} = q_out;

    gdst_back #(
        .MAX_VERTICES(MAX_VERTICES),
        .DEGREE_BITS (DEGREE_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fe_wr_en  (wr_en),
        .fe_wr_addr(wr_addr),
        .fe_wr_data(wr_data),
        .job_empty (q_empty),
        .job_pop   (q_pop),
        .job_count (be_count),
        .job_total (be_total),
        .job_flags (be_flags),
        .job_done  (job_done),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .result    (result)
    );

    assign m_graphic  = result.graphic;
    assign m_overflow = result.overflow;

    `GDST_ASSERT_IMP(a_ovf_not_graphic, aclk, aresetn, m_valid && m_overflow, !m_graphic)
    `GDST_ASSERT_NXT(a_last_blocks, aclk, aresetn, s_valid && s_ready && s_last, !s_ready)
    `GDST_ASSERT_IMP(a_no_push_full, aclk, aresetn, push, !q_full)

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;

    localparam int MAX_VERTICES = 1024;
    localparam int WATCHDOG_LIMIT = 200000;

    class degree_scoreboard;
        bit [15:0]   sequence_degrees[$];
        bit          seq_overflowed;
        bit [1:0]    pending_results[$];
        int          errors;
        int          results_seen;
        int          graphic_seen;
        int          overflow_seen;

        function bit erdos_gallai(bit [15:0] degs[$]);
            longint total;
            longint left;
            longint right;
            int     n;
            total = 0;
            foreach (degs[i]) total += degs[i];
            if (total % 2 != 0) return 0;
            degs.rsort();
            n = degs.size();
            left = 0;
            for (int k = 1; k <= n; k++) begin
                left += degs[k - 1];
                right = longint'(k) * (k - 1);
                for (int i = k; i < n; i++)
                    right += (degs[i] < k) ? degs[i] : k;
                if (left > right) return 0;
            end
            return 1;
        endfunction

        function void note_word(bit [15:0] degree, bit last);
            bit [1:0] res;
            if (sequence_degrees.size() < MAX_VERTICES)
                sequence_degrees.insert(sequence_degrees.size(), degree);
            else
                seq_overflowed = 1;
            if (last) begin
                if (seq_overflowed)
                    res = 2'b01;
                else
                    res = {erdos_gallai(sequence_degrees), 1'b0};
                pending_results.insert(pending_results.size(), res);
                sequence_degrees.delete();
                seq_overflowed = 0;
            end
        endfunction

        function void check_result(bit graphic, bit overflow);
            bit [1:0] want;
            results_seen++;
            graphic_seen += graphic;
            overflow_seen += overflow;
            if (pending_results.size() == 0) begin
                $error("unexpected result word graphic=%0d overflow=%0d", graphic, overflow);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (graphic !== want[1]) begin
                $error("graphic expected %0d actual %0d", want[1], graphic);
                errors++;
            end
            if (overflow !== want[0]) begin
                $error("overflow expected %0d actual %0d", want[0], overflow);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [15:0] s_degree = 0;
    logic        s_last = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic        m_graphic;
    logic        m_overflow;

    degree_scoreboard sb = new();
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold_cycles = 0;
    int words_sent = 0;
    int idle_cycles = 0;

    graphic_degree_sequence_test u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_degree(s_degree), .s_last(s_last),
        .m_valid(m_valid), .m_ready(m_ready), .m_graphic(m_graphic), .m_overflow(m_overflow)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        if (rx_hold_cycles > 0) begin
            m_ready <= 0;
            rx_hold_cycles = rx_hold_cycles - 1;
        end else begin
            m_ready <= aresetn && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_graphic, m_overflow);
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_word(bit [15:0] degree, bit last);
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_valid <= 1;
        s_degree <= degree;
        s_last <= last;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(degree, last);
        words_sent++;
    endtask

    task automatic send_sequence(bit [15:0] degs[$]);
        foreach (degs[i]) send_word(degs[i], i == degs.size() - 1);
    endtask

    // degrees of a random loopless multigraph, optionally disturbed, or random degrees
    task automatic send_random_sequence();
        bit [15:0] degs[$];
        int n;
        int a;
        int b;
        n = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (int i = 0; i < n; i++) degs.insert(degs.size(), 16'(0));
        if ($urandom_range(9) < 7) begin
            if (n > 1) begin
                repeat ($urandom_range(n * 2)) begin
                    a = $urandom_range(n - 1);
                    b = $urandom_range(n - 1);
                    if (a != b) begin
                        degs[a]++;
                        degs[b]++;
                    end
                end
            end
            case ($urandom_range(5))
                0: degs[$urandom_range(n - 1)]++;
                1: degs[$urandom_range(n - 1)] += 2;
                default: ;
            endcase
        end else begin
            foreach (degs[i])
                degs[i] = ($urandom_range(7) == 0) ? $urandom : $urandom_range(n);
        end
        send_sequence(degs);
    endtask

    task automatic send_list(int vals[$]);
        bit [15:0] degs[$];
        foreach (vals[i]) degs.insert(degs.size(), 16'(vals[i]));
        send_sequence(degs);
    endtask

    initial begin
        bit [15:0] big[$];
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        send_list('{0});
        send_list('{1});
        send_list('{1, 1});
        send_list('{2, 2, 2});
        send_list('{3, 3, 1, 1});
        send_list('{65535, 1});
        send_list('{65534, 0, 0});
        send_list('{0, 0, 0, 0});
        send_list('{3, 3, 3, 3});
        send_list('{2, 1, 1});

        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 59 : 0;
            rx_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 10 : 0;
            if (phase == 2) rx_hold_cycles = 600;
            while (words_sent < 250 * (phase + 1)) send_random_sequence();
        end

        // one word past a full store
        for (int i = 0; i <= MAX_VERTICES; i++) big.insert(big.size(), 16'(0));
        send_sequence(big);
        send_list('{1, 1});

        @(negedge aclk);
        s_valid <= 0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);

        $display("covered %0d degree words in %0d sequences: %0d graphic, %0d overflowed",
                 words_sent, sb.results_seen, sb.graphic_seen, sb.overflow_seen);
        $display("idling in both directions, a long receiver hold-off, an overflowed store");
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[graphic_degree_sequence_test.f]
+incdir+rtl
rtl/gdst_pkg.sv
rtl/gdst_front.sv
rtl/gdst_fifo.sv
rtl/gdst_back.sv
rtl/graphic_degree_sequence_test.sv
tb/testbench.sv
